@@ design/vctf_pkg.sv @@
// ----------------------------------------------------------------------------
// vctf_pkg
// Shared types and constants for the vertex component to float converter.
// ----------------------------------------------------------------------------
`default_nettype none

package vctf_pkg;

    localparam logic [2:0] FMT_S8  = 3'd0;
    localparam logic [2:0] FMT_U8  = 3'd1;
    localparam logic [2:0] FMT_S16 = 3'd2;
    localparam logic [2:0] FMT_U16 = 3'd3;
    localparam logic [2:0] FMT_U32 = 3'd4;
    localparam logic [2:0] FMT_F32 = 3'd5;

    localparam logic CFG_FORMAT    = 1'b0;
    localparam logic CFG_NORMALIZE = 1'b1;

    localparam int FixW = 80;
    localparam int LzW  = 7;

    // Fixed-point value: bits 79:48 integer part, bits 47:0 fraction.
    typedef struct packed {
        logic            pass;
        logic [31:0]     pass_bits;
        logic            sign;
        logic [FixW-1:0] fix;
        logic            sticky;
    } t_prep;

    typedef struct packed {
        logic            pass;
        logic [31:0]     pass_bits;
        logic            sign;
        logic            zero;
        logic [LzW-1:0]  lz;
        logic [23:0]     mant;
        logic            guard;
        logic            sticky;
    } t_norm;

endpackage

`default_nettype wire

@@ design/vctf_prep.sv @@
// ----------------------------------------------------------------------------
// vctf_prep
// Decodes the raw component into sign and a fixed-point magnitude, or marks float32 input for pass-through.
// ----------------------------------------------------------------------------
`default_nettype none

module vctf_prep (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [2:0]           i_format,
    input  wire logic                 i_normalize,
    input  wire logic [31:0]          i_raw_bits,
    output vctf_pkg::t_prep           o_prep
);

    vctf_pkg::t_prep n_prep;
    vctf_pkg::t_prep r_prep;
    logic [8:0]      mag8;
    logic [16:0]     mag16;

    always_comb begin
        mag8  = i_raw_bits[7] ? (9'd256 - {1'b0, i_raw_bits[7:0]}) : {1'b0, i_raw_bits[7:0]};
        mag16 = i_raw_bits[15] ? (17'd65536 - {1'b0, i_raw_bits[15:0]})
                               : {1'b0, i_raw_bits[15:0]};
        n_prep           = '0;
        n_prep.pass_bits = 32'd0;
        case (i_format)
            vctf_pkg::FMT_F32: begin
                n_prep.pass      = 1'b1;
                n_prep.pass_bits = i_raw_bits;
            end
            vctf_pkg::FMT_U32: begin
                n_prep.fix = {i_raw_bits, 48'd0};
            end
            vctf_pkg::FMT_U8: begin
                if (!i_normalize) begin
                    n_prep.fix = {24'd0, i_raw_bits[7:0], 48'd0};
                end else if (i_raw_bits[7:0] == 8'hFF) begin
                    n_prep.fix = {32'd1, 48'd0};
                end else begin
                    n_prep.fix    = {32'd0, {6{i_raw_bits[7:0]}}};
                    n_prep.sticky = (i_raw_bits[7:0] != 8'd0);
                end
            end
            vctf_pkg::FMT_U16: begin
                if (!i_normalize) begin
                    n_prep.fix = {16'd0, i_raw_bits[15:0], 48'd0};
                end else if (i_raw_bits[15:0] == 16'hFFFF) begin
                    n_prep.fix = {32'd1, 48'd0};
                end else begin
                    n_prep.fix    = {32'd0, {3{i_raw_bits[15:0]}}};
                    n_prep.sticky = (i_raw_bits[15:0] != 16'd0);
                end
            end
            vctf_pkg::FMT_S8: begin
                n_prep.sign = i_raw_bits[7];
                if (!i_normalize) begin
                    n_prep.fix = {23'd0, mag8, 48'd0};
                end else if (mag8 >= 9'd127) begin
                    n_prep.fix = {32'd1, 48'd0};
                end else begin
                    n_prep.fix    = {32'd0, {6{mag8[6:0]}}, mag8[6:1]};
                    n_prep.sticky = (mag8 != 9'd0);
                end
            end
            vctf_pkg::FMT_S16: begin
                n_prep.sign = i_raw_bits[15];
                if (!i_normalize) begin
                    n_prep.fix = {15'd0, mag16, 48'd0};
                end else if (mag16 >= 17'd32767) begin
                    n_prep.fix = {32'd1, 48'd0};
                end else begin
                    n_prep.fix    = {32'd0, {3{mag16[14:0]}}, mag16[14:12]};
                    n_prep.sticky = (mag16 != 17'd0);
                end
            end
            default: begin
                n_prep.pass = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep <= n_prep;
        end
    end

    assign o_prep = r_prep;

endmodule

`default_nettype wire

@@ design/vctf_norm.sv @@
// ----------------------------------------------------------------------------
// vctf_norm
// Leading-zero count, then normalizing shift with guard and sticky bits.
// ----------------------------------------------------------------------------
`default_nettype none

module vctf_norm (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  vctf_pkg::t_prep           i_prep,
    output vctf_pkg::t_norm           o_norm
);

    localparam int FixW = vctf_pkg::FixW;
    localparam int LzW  = vctf_pkg::LzW;

    logic [LzW-1:0]  n_lz;
    logic [LzW-1:0]  r_lz;
    vctf_pkg::t_prep r_prep;
    logic            r_zero;
    logic [FixW-1:0] shifted;
    vctf_pkg::t_norm n_norm;
    vctf_pkg::t_norm r_norm;

    always_comb begin
        n_lz = '0;
        for (int k = 0; k < FixW; k++) begin
            if (i_prep.fix[k]) begin
                n_lz = LzW'(FixW - 1 - k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lz   <= n_lz;
            r_prep <= i_prep;
            r_zero <= (i_prep.fix == '0);
        end
    end

    always_comb begin
        shifted          = r_prep.fix << r_lz;
        n_norm.pass      = r_prep.pass;
        n_norm.pass_bits = r_prep.pass_bits;
        n_norm.sign      = r_prep.sign;
        n_norm.zero      = r_zero;
        n_norm.lz        = r_lz;
        n_norm.mant      = shifted[FixW-1 -: 24];
        n_norm.guard     = shifted[FixW-25];
        n_norm.sticky    = (shifted[FixW-26:0] != '0) | r_prep.sticky;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm <= n_norm;
        end
    end

    assign o_norm = r_norm;

endmodule

`default_nettype wire

@@ design/vctf_pack.sv @@
// ----------------------------------------------------------------------------
// vctf_pack
// Rounds to nearest even and packs the single precision result.
// ----------------------------------------------------------------------------
`default_nettype none

module vctf_pack (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  vctf_pkg::t_norm           i_norm,
    output logic [31:0]               o_result_bits
);

    logic        round_up;
    logic [24:0] mant_r;
    logic [7:0]  expo;
    logic [31:0] n_result;
    logic [31:0] r_result;

    always_comb begin
        round_up = i_norm.guard & (i_norm.sticky | i_norm.mant[0]);
        mant_r   = {1'b0, i_norm.mant} + {24'd0, round_up};
        expo     = 8'd158 - {1'b0, i_norm.lz} + {7'd0, mant_r[24]};
        if (i_norm.pass) begin
            n_result = i_norm.pass_bits;
        end else if (i_norm.zero) begin
            n_result = 32'd0;
        end else if (mant_r[24]) begin
            n_result = {i_norm.sign, expo, mant_r[23:1]};
        end else begin
            n_result = {i_norm.sign, expo, mant_r[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_result_bits = r_result;

endmodule

`default_nettype wire

@@ design/vertex_component_to_float.sv @@
// ----------------------------------------------------------------------------
// vertex_component_to_float
// Converts one raw vertex attribute component to single precision.
//
// The input channel (i_valid, o_stall, i_raw_bits) takes one component per
// transfer; the output channel (o_valid, i_stall, o_result_bits) returns one
// single precision word per transfer, in order. The format and normalize
// registers are written through i_cfg_we, i_cfg_index and i_cfg_data; the
// user must see that they are written only while no transfer is in flight,
// as the block itself does not enforce this. The four register stages are
// decode, leading zero count, normalizing shift, and rounding; each takes a
// new item every cycle unless the pipeline is stalled, so throughput is one
// transfer per cycle while the receiver does not stall.
// Reset clears all valid bits and sets the format to float32 with
// normalization off. When the receiver stalls with a result waiting, the
// whole pipeline holds and o_stall is raised toward the sender.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_component_to_float (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_raw_bits,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_result_bits,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [2:0]  i_cfg_data
);

    logic [2:0]      r_format;
    logic            r_normalize;
    logic [3:0]      r_valid;
    logic            en;
    vctf_pkg::t_prep prep;
    vctf_pkg::t_norm norm;

    assign en      = !(r_valid[3] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_valid[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format    <= vctf_pkg::FMT_F32;
            r_normalize <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vctf_pkg::CFG_FORMAT:    r_format    <= i_cfg_data;
                vctf_pkg::CFG_NORMALIZE: r_normalize <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    vctf_prep u_prep (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_format    (r_format),
        .i_normalize (r_normalize),
        .i_raw_bits  (i_raw_bits),
        .o_prep      (prep)
    );

    vctf_norm u_norm (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_prep (prep),
        .o_norm (norm)
    );

    vctf_pack u_pack (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_norm        (norm),
        .o_result_bits (o_result_bits)
    );

endmodule

`default_nettype wire

@@ design/vctf_checker.sv @@
// ----------------------------------------------------------------------------
// vctf_checker
// Port-level checks on the converter's handshake behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module vctf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_result_bits
);

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_bits)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall
        |=> o_valid)
        else $error("result missing after four free cycles");

endmodule

bind vertex_component_to_float vctf_checker u_vctf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_result_bits (o_result_bits)
);

`default_nettype wire
